[design/wrcs_pkg.sv]
// Shared constants, codes and control types of the weighted random child selector.
package wrcs_pkg;

  localparam int unsigned MAX_CHILDREN = 16;
  localparam int unsigned WEIGHT_BITS  = 32;
  localparam int unsigned CHILD_IDX_W  = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  // Sum of all weights never overflows this width.
  localparam int unsigned TOTAL_W      = WEIGHT_BITS + CHILD_IDX_W;
  localparam int unsigned RND_W        = 32;
  localparam int unsigned PROD_W       = 2 * RND_W;

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_CONNECTING = 2'd1,
    ST_READY      = 2'd2,
    ST_FAILURE    = 2'd3
  } link_state_e;

  typedef enum logic [1:0] {
    CMD_SET_WEIGHT   = 2'd0,
    CMD_STATE_REPORT = 2'd1,
    CMD_PICK         = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    DP_HOLD   = 3'd0,
    DP_CLEAR  = 3'd1,
    DP_ACCUM  = 3'd2,
    DP_MUL_LO = 3'd3,
    DP_MUL_HI = 3'd4,
    DP_KEY    = 3'd5
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_ctrl_t;

  typedef struct packed {
    logic total_zero;  // accumulator holds zero
    logic hit;         // accumulator plus current weight exceeds the key
  } dp_status_t;

endpackage

[design/weighted_random_child_selector_unit.sv]
// Top level of the weighted random child selector: command sequencer and result registers.
//
// An item is taken when start_i is high while busy_o is low; busy_o stays high until the
// single result of that item has been shown. The result is on the result ports for
// exactly one cycle, marked by done_o, and the receiver cannot hold it off, so capture
// it in that cycle. set_weight, state_report and undefined commands go from S_AGG
// straight to S_DONE, as does a pick while the aggregate is connecting or idle; that
// pick returns pick_valid_o low. A pick in ready or transient failure walks the table
// twice through one shared adder: one pass over all 16 entries sums the weights of the
// pick set, S_MUL_LO, S_MUL_HI and S_KEY form key = (random_word * total) >> 32 on one
// 32x32 multiplier, and a second pass accumulates again until the running sum exceeds
// the key. When the pick set has a zero total, the pick ends after the first pass with
// pick_valid_o low.
// Weight and state writes land in the table at the accept edge, so aggregate_state_o
// always reflects the item itself.
module weighted_random_child_selector_unit
  import wrcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  child_index_i,
  input  logic [31:0] new_weight_i,
  input  logic [1:0]  reported_state_i,
  input  logic [31:0] random_word_i,
  output logic [1:0]  aggregate_state_o,
  output logic        pick_valid_o,
  output logic [3:0]  chosen_child_o,
  output logic        exit_idle_request_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_AGG    = 7'b0000010,
    S_SUM    = 7'b0000100,
    S_MUL_LO = 7'b0001000,
    S_MUL_HI = 7'b0010000,
    S_KEY    = 7'b0100000,
    S_DONE   = 7'b1000000
  } fsm_e;

  localparam logic [CHILD_IDX_W-1:0] LAST_IDX = CHILD_IDX_W'(MAX_CHILDREN - 1);

  // Note: the scan pass reuses S_SUM's walk but with compare; tracked by scan_q.
  fsm_e                   state_q, state_d;
  logic                   scan_q, scan_d;
  logic [CHILD_IDX_W-1:0] idx_q, idx_d;
  cmd_e                   cmd_q, cmd_d;
  logic [RND_W-1:0]       rnd_q, rnd_d;
  link_state_e            agg_q, agg_d;
  logic                   exit_q, exit_d;
  logic                   valid_q, valid_d;
  logic [CHILD_IDX_W-1:0] chosen_q, chosen_d;

  logic                   accept;
  logic                   idx_in_range;
  logic [CHILD_IDX_W-1:0] wr_idx;
  logic [WEIGHT_BITS-1:0] rd_weight;
  link_state_e            rd_state;
  link_state_e            agg_now;
  logic                   member;
  dp_ctrl_t               dp_ctrl;
  dp_status_t             dp_status;

  assign accept       = start_i && !busy_o;
  assign idx_in_range = 32'(child_index_i) < MAX_CHILDREN;
  assign wr_idx       = CHILD_IDX_W'(child_index_i);

  // Table writes happen right at the accept edge.
  wrcs_child_table u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_weight_en_i (accept && command_i == CMD_SET_WEIGHT && idx_in_range),
    .wr_state_en_i  (accept && command_i == CMD_STATE_REPORT && idx_in_range),
    .wr_idx_i       (wr_idx),
    .wr_weight_i    (WEIGHT_BITS'(new_weight_i)),
    .wr_state_i     (link_state_e'(reported_state_i)),
    .rd_idx_i       (idx_q),
    .rd_weight_o    (rd_weight),
    .rd_state_o     (rd_state),
    .agg_state_o    (agg_now)
  );

  wrcs_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dp_ctrl),
    .weight_i (rd_weight),
    .rnd_i    (rnd_q),
    .status_o (dp_status)
  );

  // A child belongs to the pick set when active and in the set's state.
  assign member = (rd_weight != '0) && (rd_state == agg_q);

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    rnd_d      = rnd_q;
    agg_d      = agg_q;
    exit_d     = exit_q;
    valid_d    = valid_q;
    chosen_d   = chosen_q;
    dp_ctrl.op = DP_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_e'(command_i);
          rnd_d   = random_word_i;
          exit_d  = (command_i == CMD_STATE_REPORT) &&
                    (reported_state_i == ST_IDLE);
          state_d = S_AGG;
        end
      end
      S_AGG: begin
        agg_d    = agg_now;
        valid_d  = 1'b0;
        chosen_d = '0;
        if (cmd_q == CMD_PICK && (agg_now == ST_READY || agg_now == ST_FAILURE)) begin
          dp_ctrl.op = DP_CLEAR;
          idx_d      = '0;
          scan_d     = 1'b0;
          state_d    = S_SUM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SUM: begin
        if (member) begin
          dp_ctrl.op = DP_ACCUM;
        end
        if (scan_q && member && dp_status.hit) begin
          // Stop at the first child whose running sum passes the key.
          valid_d  = 1'b1;
          chosen_d = idx_q;
          state_d  = S_DONE;
        end else if (idx_q == LAST_IDX) begin
          state_d = scan_q ? S_DONE : S_MUL_LO;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MUL_LO: begin
        if (dp_status.total_zero) begin
          state_d = S_DONE;
        end else begin
          dp_ctrl.op = DP_MUL_LO;
          state_d    = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        dp_ctrl.op = DP_MUL_HI;
        state_d    = S_KEY;
      end
      S_KEY: begin
        // Finish the key and restart the walk for the running sum.
        dp_ctrl.op = DP_KEY;
        idx_d      = '0;
        scan_d     = 1'b1;
        state_d    = S_SUM;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rnd_q    <= rnd_d;
    agg_q    <= agg_d;
    exit_q   <= exit_d;
    valid_q  <= valid_d;
    chosen_q <= chosen_d;
  end

  assign busy_o              = (state_q != S_IDLE);
  assign done_o              = (state_q == S_DONE);
  assign aggregate_state_o   = agg_q;
  assign pick_valid_o        = valid_q;
  assign chosen_child_o      = 4'(chosen_q);
  assign exit_idle_request_o = exit_q;

endmodule

[design/wrcs_child_table.sv]
// Child weight and link state table with the aggregate state reduction.
module wrcs_child_table
  import wrcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_weight_en_i,
  input  logic                   wr_state_en_i,
  input  logic [CHILD_IDX_W-1:0] wr_idx_i,
  input  logic [WEIGHT_BITS-1:0] wr_weight_i,
  input  link_state_e            wr_state_i,
  input  logic [CHILD_IDX_W-1:0] rd_idx_i,
  output logic [WEIGHT_BITS-1:0] rd_weight_o,
  output link_state_e            rd_state_o,
  output link_state_e            agg_state_o
);

  logic [WEIGHT_BITS-1:0] weight_q [MAX_CHILDREN];
  link_state_e            state_q  [MAX_CHILDREN];
  logic [MAX_CHILDREN-1:0] is_ready, is_conn, is_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHILDREN; i++) begin
        weight_q[i] <= '0;
        state_q[i]  <= ST_CONNECTING;
      end
    end else begin
      if (wr_weight_en_i) begin
        weight_q[wr_idx_i] <= wr_weight_i;
      end
      // Hold a failure until ready is reported.
      if (wr_state_en_i &&
          (state_q[wr_idx_i] != ST_FAILURE || wr_state_i == ST_READY)) begin
        state_q[wr_idx_i] <= wr_state_i;
      end
    end
  end

  assign rd_weight_o = weight_q[rd_idx_i];
  assign rd_state_o  = state_q[rd_idx_i];

  always_comb begin
    for (int i = 0; i < MAX_CHILDREN; i++) begin
      is_ready[i] = (weight_q[i] != '0) && (state_q[i] == ST_READY);
      is_conn[i]  = (weight_q[i] != '0) && (state_q[i] == ST_CONNECTING);
      is_idle[i]  = (weight_q[i] != '0) && (state_q[i] == ST_IDLE);
    end
    if (|is_ready) begin
      agg_state_o = ST_READY;
    end else if (|is_conn) begin
      agg_state_o = ST_CONNECTING;
    end else if (|is_idle) begin
      agg_state_o = ST_IDLE;
    end else begin
      agg_state_o = ST_FAILURE;
    end
  end

endmodule

[design/wrcs_datapath.sv]
// Shared accumulate, compare and multiply unit for totals, key and running sum.
module wrcs_datapath
  import wrcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_ctrl_t               ctrl_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic [RND_W-1:0]       rnd_i,
  output dp_status_t             status_o
);

  logic [TOTAL_W-1:0] acc_q, acc_d;
  logic [TOTAL_W-1:0] key_q, key_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [PROD_W-1:0]  acc_ext;
  logic [RND_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [TOTAL_W-1:0] sum;

  assign acc_ext = PROD_W'(acc_q);
  assign mul_b   = (ctrl_i.op == DP_MUL_HI) ? acc_ext[PROD_W-1:RND_W] : acc_ext[RND_W-1:0];
  assign mul_p   = PROD_W'(rnd_i) * PROD_W'(mul_b);
  assign sum     = acc_q + TOTAL_W'(weight_i);

  assign status_o.total_zero = (acc_q == '0);
  assign status_o.hit        = (sum > key_q);

  always_comb begin
    acc_d  = acc_q;
    key_d  = key_q;
    prod_d = prod_q;
    unique case (ctrl_i.op)
      DP_HOLD:   ;
      DP_CLEAR:  acc_d = '0;
      DP_ACCUM:  acc_d = sum;
      DP_MUL_LO: prod_d = mul_p;
      DP_MUL_HI: begin
        key_d  = TOTAL_W'(prod_q[PROD_W-1:RND_W]);
        prod_d = mul_p;
      end
      DP_KEY: begin
        key_d = key_q + TOTAL_W'(prod_q);
        acc_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prod_q <= prod_d;
  end

endmodule
